[rtl/vrt_pkg.sv]
// vrt_pkg: shared types and constants for the rotated trilinear resampler
// no dependencies
package vrt_pkg;

  localparam int unsigned CoefFrac  = 14;
  localparam int unsigned MaxExtent = 32;

  typedef enum logic [2:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_COEF_X    = 3'd3,
    REG_COEF_Y    = 3'd4,
    REG_COEF_Z    = 3'd5,
    REG_MASK_MODE = 3'd6
  } reg_idx_e;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [4:0]  pos_z;
    logic signed [15:0] voxel_in;
    logic [15:0] mask_in;
  } in_item_t;

  typedef struct packed {
    logic        inside_res;
    logic signed [15:0] voxel_out;
    logic [15:0] mask_out;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  size_x;
    logic [5:0]  size_y;
    logic [5:0]  size_z;
    logic [47:0] coef_x;
    logic [47:0] coef_y;
    logic [47:0] coef_z;
    logic        mask_mode;
  } cfg_t;

endpackage

[rtl/volume_rotate_trilinear_unit.sv]
// volume_rotate_trilinear_unit: top level of the rotated trilinear resampler
// depends on vrt_pkg, vrt_ram, vrt_cfg, vrt_coord, vrt_lerp
//
// input channel carries write and query transfers; a write stores one density
// and one mask sample, a query yields one result transfer on the output channel
// the store is split into eight banks by coordinate parity, each voxel held once,
// so the eight neighbours of a cell are read together, one from each bank
// pipeline: offsets, coordinate products, coordinate sum and bounds, bank read,
// x lerp, y lerp, z lerp, rounding and output register
// throughput one transfer per cycle unless the output stalls; a write reaches the
// banks at the bank read stage, in step with the queries, so each query sees
// exactly the writes that came before it
// when the output is stalled the whole pipe holds, and in_stall_o rises
// at reset the pipe empties and the valid and config registers take their reset
// values; the stores are undefined until written
// apb writes are meant only while the pipe is empty
module volume_rotate_trilinear_unit import vrt_pkg::*; #(
  parameter int unsigned FracBits  = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = $clog2(MaxExtent);
  localparam int unsigned BW = AW - 1;
  localparam int unsigned BD = 1 << (3 * BW);
  localparam int unsigned WW = FracBits + 1;
  localparam int unsigned SW = 17 + 2 * FracBits + 4;
  localparam int unsigned NS = 8;

  cfg_t cfg;
  logic en;
  logic [NS-1:0] vld_q;
  logic acc;

  vrt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // stage 0: offsets
  logic [5:0] sz [3];
  logic signed [6:0] off_q [3];
  always_comb begin
    sz[0] = (cfg.size_x > 6'(MaxExtent)) ? 6'(MaxExtent) : cfg.size_x;
    sz[1] = (cfg.size_y > 6'(MaxExtent)) ? 6'(MaxExtent) : cfg.size_y;
    sz[2] = (cfg.size_z > 6'(MaxExtent)) ? 6'(MaxExtent) : cfg.size_z;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      off_q[0] <= $signed({2'b0, in_data_i.pos_x}) - $signed({2'b0, sz[0][5:1]});
      off_q[1] <= $signed({2'b0, in_data_i.pos_y}) - $signed({2'b0, sz[1][5:1]});
      off_q[2] <= $signed({2'b0, in_data_i.pos_z}) - $signed({2'b0, sz[2][5:1]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NS-2:0], acc && in_data_i.req_type == REQ_QUERY};
  end

  // stages 1-2: coordinates
  logic           ins [3];
  logic [AW-1:0]  base [3];
  logic [WW-1:0]  w2 [3];
  logic [47:0]    coefs [3];
  assign coefs[0] = cfg.coef_x;
  assign coefs[1] = cfg.coef_y;
  assign coefs[2] = cfg.coef_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    vrt_coord #(.MaxExtent(MaxExtent), .FracBits(FracBits)) u_coord (
      .clk_i, .en_i(en), .size_i(sz[a]), .coef_i(coefs[a]),
      .off_x_i(off_q[0]), .off_y_i(off_q[1]), .off_z_i(off_q[2]),
      .inside_o(ins[a]), .base_o(base[a]), .w2_o(w2[a])
    );
  end

  // stage 3: banked read; corner k bank = parity of (base + bit)
  logic          wr_en;
  logic [2:0]    wr_bank;
  logic [3*BW-1:0] wr_addr;
  assign wr_en   = acc && in_data_i.req_type == REQ_WRITE
                   && (6'(in_data_i.pos_x) < 6'(MaxExtent))
                   && (6'(in_data_i.pos_y) < 6'(MaxExtent))
                   && (6'(in_data_i.pos_z) < 6'(MaxExtent));
  assign wr_bank = {in_data_i.pos_z[0], in_data_i.pos_y[0], in_data_i.pos_x[0]};
  assign wr_addr = {in_data_i.pos_z[AW-1:1], in_data_i.pos_y[AW-1:1], in_data_i.pos_x[AW-1:1]};

  // writes travel to the bank read stage
  logic [2:0]      wr_vld_q;
  logic [2:0]      wr_bank_q [3];
  logic [3*BW-1:0] wr_addr_q [3];
  logic [31:0]     wr_data_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wr_vld_q <= '0;
    else if (en) wr_vld_q <= {wr_vld_q[1:0], wr_en};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wr_bank_q[0] <= wr_bank;
      wr_addr_q[0] <= wr_addr;
      wr_data_q[0] <= {in_data_i.voxel_in, in_data_i.mask_in};
      for (int i = 1; i < 3; i++) begin
        wr_bank_q[i] <= wr_bank_q[i-1];
        wr_addr_q[i] <= wr_addr_q[i-1];
        wr_data_q[i] <= wr_data_q[i-1];
      end
    end
  end

  logic [31:0] rd_data [8];
  logic [2:0]  par_q;
  logic        ins_q;
  logic [WW-1:0] w2_q [3];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [AW-1:0] cx, cy, cz;
    always_comb begin
      cx = base[0] + AW'((b & 1) != (base[0][0] ? 1 : 0));
      cy = base[1] + AW'(((b >> 1) & 1) != (base[1][0] ? 1 : 0));
      cz = base[2] + AW'(((b >> 2) & 1) != (base[2][0] ? 1 : 0));
    end
    vrt_ram #(.Width(32), .Depth(BD)) u_ram (
      .clk_i, .we_i(en && wr_vld_q[2] && wr_bank_q[2] == 3'(b)), .waddr_i(wr_addr_q[2]),
      .wdata_i(wr_data_q[2]),
      .re_i(en), .raddr_i({cz[AW-1:1], cy[AW-1:1], cx[AW-1:1]}),
      .rdata_o(rd_data[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      par_q <= {base[2][0], base[1][0], base[0][0]};
      ins_q <= ins[0] && ins[1] && ins[2];
      w2_q  <= w2;
    end
  end

  // corner k sits in bank k xor base parity
  logic signed [16:0] dv [8];
  logic signed [16:0] mv [8];
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      dv[k] = {rd_data[3'(k) ^ par_q][31], rd_data[3'(k) ^ par_q][31:16]};
      mv[k] = {1'b0, rd_data[3'(k) ^ par_q][15:0]};
    end
  end

  // stages 4-6: interpolation
  logic signed [SW-1:0] dsum, msum;
  vrt_lerp #(.FracBits(FracBits)) u_dlerp (
    .clk_i, .en_i(en), .v_i(dv), .w2_i(w2_q), .sum_o(dsum));
  vrt_lerp #(.FracBits(FracBits)) u_mlerp (
    .clk_i, .en_i(en), .v_i(mv), .w2_i(w2_q), .sum_o(msum));

  logic [2:0] ins_d_q;
  logic [2:0] mm_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ins_d_q <= {ins_d_q[1:0], ins_q};
      mm_q    <= {mm_q[1:0], cfg.mask_mode};
    end
  end

  // stage 7: rounding, saturation, output register
  localparam logic signed [SW-1:0] Half = SW'(1) <<< (2 * FracBits - 1);
  localparam logic signed [SW-1:0] MHalf = SW'(16384) <<< (2 * FracBits);
  logic signed [SW-1:0] dr, mr;
  out_item_t res;
  always_comb begin
    dr = (dsum + Half) >>> (2 * FracBits);
    mr = (msum + Half) >>> (2 * FracBits);
    res.inside_res = ins_d_q[2];
    if (dr > SW'(32767))       res.voxel_out = 16'sh7fff;
    else if (dr < -SW'(32768)) res.voxel_out = 16'sh8000;
    else                       res.voxel_out = dr[15:0];
    if (mm_q[2])               res.mask_out = (msum >= MHalf) ? 16'h8000 : 16'h0000;
    else if (mr < 0)           res.mask_out = 16'h0000;
    else if (mr > SW'(65535))  res.mask_out = 16'hffff;
    else                       res.mask_out = mr[15:0];
    if (!ins_d_q[2]) begin
      res.voxel_out = '0;
      res.mask_out  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_data_o <= res;
  end
  assign out_valid_o = vld_q[NS-1];
endmodule

[rtl/vrt_ram.sv]
// vrt_ram: generic single-write, single-read ram with registered read
// no dependencies
module vrt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/vrt_cfg.sv]
// vrt_cfg: apb register file for sizes, rotation coefficients and mask mode
// depends on vrt_pkg
module vrt_cfg import vrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);
  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x    <= 6'd32;
      cfg_q.size_y    <= 6'd32;
      cfg_q.size_z    <= 6'd32;
      cfg_q.coef_x    <= 48'h0000_0000_4000;
      cfg_q.coef_y    <= 48'h0000_4000_0000;
      cfg_q.coef_z    <= 48'h4000_0000_0000;
      cfg_q.mask_mode <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_SIZE_X:    cfg_q.size_x    <= pwdata[5:0];
        REG_SIZE_Y:    cfg_q.size_y    <= pwdata[5:0];
        REG_SIZE_Z:    cfg_q.size_z    <= pwdata[5:0];
        REG_COEF_X:    cfg_q.coef_x    <= pwdata[47:0];
        REG_COEF_Y:    cfg_q.coef_y    <= pwdata[47:0];
        REG_COEF_Z:    cfg_q.coef_z    <= pwdata[47:0];
        REG_MASK_MODE: cfg_q.mask_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIZE_X:    prdata = {58'd0, cfg_q.size_x};
      REG_SIZE_Y:    prdata = {58'd0, cfg_q.size_y};
      REG_SIZE_Z:    prdata = {58'd0, cfg_q.size_z};
      REG_COEF_X:    prdata = {16'd0, cfg_q.coef_x};
      REG_COEF_Y:    prdata = {16'd0, cfg_q.coef_y};
      REG_COEF_Z:    prdata = {16'd0, cfg_q.coef_z};
      REG_MASK_MODE: prdata = {63'd0, cfg_q.mask_mode};
      default:       prdata = 64'd0;
    endcase
  end
endmodule

[rtl/vrt_coord.sv]
// vrt_coord: two-stage source coordinate for one axis (products, then sum and bounds)
// depends on vrt_pkg
module vrt_coord import vrt_pkg::*; #(
  parameter int unsigned MaxExtent = 32,
  parameter int unsigned FracBits  = 14,
  localparam int unsigned AW = $clog2(MaxExtent)
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [5:0]          size_i,
  input  logic [47:0]         coef_i,
  input  logic signed [6:0]   off_x_i,
  input  logic signed [6:0]   off_y_i,
  input  logic signed [6:0]   off_z_i,
  output logic                inside_o,
  output logic [AW-1:0]       base_o,
  output logic [FracBits:0]   w2_o
);
  // products registered, then sum and bounds
  logic signed [22:0] p0_q, p1_q, p2_q;
  logic [5:0]         size_q;
  logic signed [25:0] r;
  logic signed [11:0] fl;
  logic [CoefFrac-1:0] frac;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= $signed(coef_i[15:0])  * off_x_i;
      p1_q   <= $signed(coef_i[31:16]) * off_y_i;
      p2_q   <= $signed(coef_i[47:32]) * off_z_i;
      size_q <= size_i;
    end
  end

  always_comb begin
    r = 26'(p0_q) + 26'(p1_q) + 26'(p2_q)
      + $signed({6'd0, size_q[5:1], 15'd0} >> (15 - CoefFrac));
    fl   = 12'(r >>> CoefFrac);
    frac = r[CoefFrac-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inside_o <= !r[25] && (fl < $signed({6'd0, size_q}) - 12'sd1);
      base_o   <= fl[AW-1:0];
      if (FracBits >= CoefFrac) w2_o <= (FracBits+1)'({frac} << (FracBits - CoefFrac));
      else                      w2_o <= (FracBits+1)'({frac} >> (CoefFrac - FracBits));
    end
  end
endmodule

[rtl/vrt_lerp.sv]
// vrt_lerp: three-stage trilinear combine of eight samples (x, then y with rounding, then z)
// depends on vrt_pkg
module vrt_lerp import vrt_pkg::*; #(
  parameter int unsigned FracBits = 14,
  localparam int unsigned WW = FracBits + 1,
  localparam int unsigned SW = 17 + 2 * FracBits + 4
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [16:0]  v_i [8],
  input  logic [WW-1:0]       w2_i [3],
  output logic signed [SW-1:0] sum_o
);
  localparam logic [WW-1:0] One = WW'(1) << FracBits;
  logic signed [17+WW:0]     lx_q [4];
  logic [WW-1:0]             wy_q, wz_q, wz2_q;
  logic signed [SW-1:0]      q_q [2];
  logic signed [SW-1:0]      t0, t1;
  logic signed [SW-1:0]      ax, bx;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++)
        lx_q[i] <= v_i[2*i] * $signed({1'b0, One - w2_i[0]})
                 + v_i[2*i+1] * $signed({1'b0, w2_i[0]});
      wy_q <= w2_i[1];
      wz_q <= w2_i[2];
    end
  end

  always_comb begin
    t0 = SW'(lx_q[0]) * $signed({1'b0, One - wy_q}) + SW'(lx_q[1]) * $signed({1'b0, wy_q});
    t1 = SW'(lx_q[2]) * $signed({1'b0, One - wy_q}) + SW'(lx_q[3]) * $signed({1'b0, wy_q});
    t0 = (t0 + (SW'(1) <<< (FracBits - 1))) >>> FracBits;
    t1 = (t1 + (SW'(1) <<< (FracBits - 1))) >>> FracBits;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q[0] <= t0;
      q_q[1] <= t1;
      wz2_q  <= wz_q;
    end
  end

  assign ax = q_q[0] * $signed({1'b0, One - wz2_q});
  assign bx = q_q[1] * $signed({1'b0, wz2_q});

  always_ff @(posedge clk_i) begin
    if (en_i) sum_o <= ax + bx;
  end
endmodule

[rtl/vrt_checker.sv]
// vrt_checker: port-level checks for the resampler, bound to the top level
// depends on vrt_pkg
module vrt_checker import vrt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input not stalled behind output stall");
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.inside_res |-> out_data_o.voxel_out == 16'd0
      && out_data_o.mask_out == 16'd0)
    else $error("outside result not zero");
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |-> !in_stall_o)
    else $error("input stalled with free output");
endmodule

bind volume_rotate_trilinear_unit vrt_checker u_vrt_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
